[rtl/m4inv_pkg.sv]
// Shared types, widths and index helpers for the 4x4 matrix inverse.
// Used by matrix4x4_inverse, m4inv_mul, m4inv_div and the testbench; depends on nothing else.
package m4inv_pkg;

  localparam int ELEM_WIDTH    = 32;
  localparam int FRAC_BITS_DEF = 16;
  // Exact adjugate entry: sum of six triple products.
  localparam int ADJ_WIDTH     = 3 * ELEM_WIDTH + 3;
  // Exact determinant, also the width of the shared multiplier datapath.
  localparam int PROD_WIDTH    = 4 * ELEM_WIDTH + 6;

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;

  typedef struct packed {
    elem_t elem_col0;
    elem_t elem_col1;
    elem_t elem_col2;
    elem_t elem_col3;
  } in_item_t;

  typedef struct packed {
    elem_t       inv_col0;
    elem_t       inv_col1;
    elem_t       inv_col2;
    elem_t       inv_col3;
    logic [1:0]  out_row;
    logic        last_row;
    logic        singular;
    logic        saturated;
  } out_item_t;

  // Index k of the three indices that remain when index ex is left out.
  function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] ex);
    skip_idx = (k >= ex) ? k + 2'd1 : k;
  endfunction

  // Minor column used by row k of triple product p (the six permutations).
  function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] k);
    logic [5:0] cols;
    unique case (p)
      3'd0:    cols = {2'd2, 2'd1, 2'd0};
      3'd1:    cols = {2'd0, 2'd2, 2'd1};
      3'd2:    cols = {2'd1, 2'd0, 2'd2};
      3'd3:    cols = {2'd1, 2'd2, 2'd0};
      3'd4:    cols = {2'd2, 2'd0, 2'd1};
      3'd5:    cols = {2'd0, 2'd1, 2'd2};
      default: cols = {2'd2, 2'd1, 2'd0};
    endcase
    unique case (k)
      2'd0:    perm_col = cols[1:0];
      2'd1:    perm_col = cols[3:2];
      default: perm_col = cols[5:4];
    endcase
  endfunction

  // The odd permutations enter the minor with a minus sign.
  function automatic logic perm_neg(input logic [2:0] p);
    perm_neg = (p >= 3'd3);
  endfunction

endpackage

[rtl/m4inv_mul.sv]
// Shift-and-add signed multiplier, one multiplier bit per cycle.
// Depends on m4inv_pkg for the element and product widths.
module m4inv_mul
  import m4inv_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  elem_t                        a,
  input  logic signed [PROD_WIDTH-1:0] b,
  output logic                         done,
  output logic signed [PROD_WIDTH-1:0] p
);

  localparam int CW = $clog2(ELEM_WIDTH);

  logic                  run_r;
  logic                  done_r;
  logic [CW-1:0]         cnt_r;
  elem_t                 a_r;
  logic [PROD_WIDTH-1:0] b_r;
  logic [PROD_WIDTH-1:0] p_r;
  logic                  last;
  logic [PROD_WIDTH-1:0] p_nxt;

  assign last = (cnt_r == CW'(ELEM_WIDTH - 1));

  // The sign bit of a carries negative weight.
  always_comb begin
    p_nxt = p_r;
    if (a_r[0]) begin
      p_nxt = last ? p_r - b_r : p_r + b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && last) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      p_r   <= '0;
      cnt_r <= '0;
    end else if (run_r) begin
      a_r   <= a_r >>> 1;
      b_r   <= b_r << 1;
      p_r   <= p_nxt;
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

[rtl/m4inv_div.sv]
// Restoring divider: (num << 2*FRAC_BITS) / dmag on magnitudes, one bit per cycle.
// Depends on m4inv_pkg for the adjugate and determinant widths.
module m4inv_div
  import m4inv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [ADJ_WIDTH-1:0]                num,
  input  logic [PROD_WIDTH-1:0]               dmag,
  output logic                                done,
  output logic [ADJ_WIDTH+2*FRAC_BITS-1:0]    q
);

  localparam int NB = ADJ_WIDTH + 2 * FRAC_BITS;
  localparam int RW = PROD_WIDTH + 1;
  localparam int CW = $clog2(NB);

  logic            run_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [NB-1:0]   n_r;
  logic [NB-1:0]   q_r;
  logic [RW-1:0]   rem_r;
  logic [RW-1:0]   shifted;
  logic [RW:0]     diff;
  logic            last;

  assign last    = (cnt_r == CW'(NB - 1));
  assign shifted = {rem_r[RW-2:0], n_r[NB-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dmag};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && last) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= {num, {(2 * FRAC_BITS){1'b0}}};
      q_r   <= '0;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (run_r) begin
      n_r   <= n_r << 1;
      cnt_r <= cnt_r + CW'(1);
      if (!diff[RW]) begin
        rem_r <= diff[RW-1:0];
        q_r   <= {q_r[NB-2:0], 1'b1};
      end else begin
        rem_r <= shifted;
        q_r   <= {q_r[NB-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

[rtl/matrix4x4_inverse.sv]
// 4x4 matrix inverse by cofactors; one input item per row, four result rows.
// After the fourth row come the triple products of the adjugate, then the
// determinant, then for each result row its four divides and the row itself;
// a singular matrix skips the divides. Elements are Q16.16 for the default
// FRAC_BITS. Input stalls until the last result row is taken. Synchronous
// active-low reset returns to row 0 with no result pending.
module matrix4x4_inverse
  import m4inv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int NB = ADJ_WIDTH + 2 * FRAC_BITS;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_LD   = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_W1   = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_W2   = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_DM   = 4'd7;
  localparam logic [3:0] S_DW   = 4'd8;
  localparam logic [3:0] S_DACC = 4'd9;
  localparam logic [3:0] S_ABS  = 4'd10;
  localparam logic [3:0] S_DV   = 4'd11;
  localparam logic [3:0] S_DW2  = 4'd12;
  localparam logic [3:0] S_SAT  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0]                   st_r;
  logic [1:0]                   row_r;
  elem_t                        mat_r [16];
  logic signed [ADJ_WIDTH-1:0]  adj_r [16];
  logic [1:0]                   ai_r;
  logic [1:0]                   aj_r;
  logic [2:0]                   perm_r;
  logic signed [ADJ_WIDTH-1:0]  acc_r;
  logic signed [PROD_WIDTH-1:0] det_r;
  logic [PROD_WIDTH-1:0]        dmag_r;
  logic                         dneg_r;
  logic                         sing_r;
  logic                         nneg_r;
  elem_t                        opb_r;
  elem_t                        res_r [3];
  logic                         sat_r;
  logic                         out_valid_r;
  out_item_t                    out_item_r;

  logic [1:0]                   kk;
  logic [1:0]                   rd_row;
  logic [1:0]                   rd_col;
  elem_t                        el;
  logic [3:0]                   adj_idx;
  logic signed [ADJ_WIDTH-1:0]  adj_rd;
  logic                         mul_start;
  logic signed [PROD_WIDTH-1:0] mul_b;
  logic                         mul_done;
  logic signed [PROD_WIDTH-1:0] mul_p;
  logic                         div_start;
  logic [ADJ_WIDTH-1:0]         div_num;
  logic                         div_done;
  logic [NB-1:0]                div_q;
  logic                         term_neg;
  logic signed [ADJ_WIDTH-1:0]  acc_nxt;
  logic                         qneg;
  logic                         big_pos;
  logic                         big_neg;
  elem_t                        res_nxt;
  logic                         sat_nxt;
  logic                         in_acc;

  // Element read: one address per cycle.
  always_comb begin
    unique case (st_r)
      S_LD:    kk = 2'd1;
      S_M2:    kk = 2'd2;
      default: kk = 2'd0;
    endcase
    rd_row = skip_idx(kk, aj_r);
    rd_col = skip_idx(perm_col(perm_r, kk), ai_r);
    if (st_r == S_DM) begin
      rd_row = 2'd0;
      rd_col = aj_r;
    end
  end

  assign el      = mat_r[{rd_row, rd_col}];
  assign adj_idx = (st_r == S_DM) ? {aj_r, 2'b00} : {ai_r, aj_r};
  assign adj_rd  = adj_r[adj_idx];

  assign mul_start = (st_r == S_M1) || (st_r == S_M2) || (st_r == S_DM);
  always_comb begin
    unique case (st_r)
      S_M1:    mul_b = PROD_WIDTH'(opb_r);
      S_M2:    mul_b = mul_p;
      default: mul_b = PROD_WIDTH'(adj_rd);
    endcase
  end

  m4inv_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (el),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign div_start = (st_r == S_DV);
  assign div_num   = adj_rd[ADJ_WIDTH-1] ? ADJ_WIDTH'(-adj_rd) : ADJ_WIDTH'(adj_rd);

  m4inv_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .dmag  (dmag_r),
    .done  (div_done),
    .q     (div_q)
  );

  // Cofactor sign and permutation sign fold into one add or subtract.
  assign term_neg = perm_neg(perm_r) ^ ai_r[0] ^ aj_r[0];
  assign acc_nxt  = term_neg ? acc_r - mul_p[ADJ_WIDTH-1:0]
                             : acc_r + mul_p[ADJ_WIDTH-1:0];

  // Saturate the quotient magnitude into the signed element range.
  assign qneg    = nneg_r ^ dneg_r;
  assign big_pos = (div_q[NB-1:ELEM_WIDTH-1] != '0);
  assign big_neg = big_pos && !((div_q[NB-1:ELEM_WIDTH-1] == (NB-ELEM_WIDTH+1)'(1)) &&
                                (div_q[ELEM_WIDTH-2:0] == '0));
  always_comb begin
    res_nxt = '0;
    sat_nxt = 1'b0;
    if (!sing_r) begin
      if (qneg) begin
        sat_nxt = big_neg;
        res_nxt = big_neg ? {1'b1, {(ELEM_WIDTH-1){1'b0}}}
                          : -elem_t'(div_q[ELEM_WIDTH-1:0]);
      end else begin
        sat_nxt = big_pos;
        res_nxt = big_pos ? {1'b0, {(ELEM_WIDTH-1){1'b1}}}
                          : elem_t'(div_q[ELEM_WIDTH-1:0]);
      end
    end
  end

  assign in_stall = !rst_n || (st_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_LOAD;
      row_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_LOAD: begin
          if (in_acc) begin
            row_r <= row_r + 2'd1;
            if (row_r == 2'd3) begin
              st_r <= S_LD;
            end
          end
        end
        S_LD:   st_r <= S_M1;
        S_M1:   st_r <= S_W1;
        S_W1:   if (mul_done) st_r <= S_M2;
        S_M2:   st_r <= S_W2;
        S_W2:   if (mul_done) st_r <= S_ACC;
        S_ACC: begin
          if (perm_r == 3'd5 && ai_r == 2'd3 && aj_r == 2'd3) begin
            st_r <= S_DM;
          end else begin
            st_r <= S_LD;
          end
        end
        S_DM:   st_r <= S_DW;
        S_DW:   if (mul_done) st_r <= S_DACC;
        S_DACC: st_r <= (aj_r == 2'd3) ? S_ABS : S_DM;
        S_ABS:  st_r <= (det_r == '0) ? S_SAT : S_DV;
        S_DV:   st_r <= S_DW2;
        S_DW2:  if (div_done) st_r <= S_SAT;
        S_SAT: begin
          if (aj_r == 2'd3) begin
            st_r        <= S_OUT;
            out_valid_r <= 1'b1;
          end else begin
            st_r <= sing_r ? S_SAT : S_DV;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (ai_r == 2'd3) begin
              st_r <= S_LOAD;
            end else begin
              st_r <= sing_r ? S_SAT : S_DV;
            end
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_LOAD: begin
        if (in_acc) begin
          mat_r[{row_r, 2'd0}] <= in_item.elem_col0;
          mat_r[{row_r, 2'd1}] <= in_item.elem_col1;
          mat_r[{row_r, 2'd2}] <= in_item.elem_col2;
          mat_r[{row_r, 2'd3}] <= in_item.elem_col3;
          ai_r   <= 2'd0;
          aj_r   <= 2'd0;
          perm_r <= 3'd0;
          acc_r  <= '0;
        end
      end
      S_LD: opb_r <= el;
      S_ACC: begin
        if (perm_r == 3'd5) begin
          adj_r[{ai_r, aj_r}] <= acc_nxt;
          acc_r  <= '0;
          perm_r <= 3'd0;
          aj_r   <= aj_r + 2'd1;
          if (aj_r == 2'd3) begin
            ai_r <= ai_r + 2'd1;
          end
          det_r <= '0;
        end else begin
          acc_r  <= acc_nxt;
          perm_r <= perm_r + 3'd1;
        end
      end
      S_DACC: begin
        det_r <= det_r + mul_p;
        aj_r  <= aj_r + 2'd1;
      end
      S_ABS: begin
        sing_r <= (det_r == '0);
        dneg_r <= det_r[PROD_WIDTH-1];
        dmag_r <= det_r[PROD_WIDTH-1] ? PROD_WIDTH'(-det_r) : PROD_WIDTH'(det_r);
        ai_r   <= 2'd0;
        aj_r   <= 2'd0;
        sat_r  <= 1'b0;
      end
      S_DV: nneg_r <= adj_rd[ADJ_WIDTH-1];
      S_SAT: begin
        if (aj_r == 2'd3) begin
          out_item_r.inv_col0  <= res_r[0];
          out_item_r.inv_col1  <= res_r[1];
          out_item_r.inv_col2  <= res_r[2];
          out_item_r.inv_col3  <= res_nxt;
          out_item_r.out_row   <= ai_r;
          out_item_r.last_row  <= (ai_r == 2'd3);
          out_item_r.singular  <= sing_r;
          out_item_r.saturated <= sat_r | sat_nxt;
        end else begin
          res_r[aj_r] <= res_nxt;
          sat_r       <= sat_r | sat_nxt;
          aj_r        <= aj_r + 2'd1;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          ai_r  <= ai_r + 2'd1;
          aj_r  <= 2'd0;
          sat_r <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[tb/tb.sv]
// Testbench for matrix4x4_inverse: sends matrices row by row and checks each
// inverse row against an exact cofactor/adjugate calculation done here.
// Depends on m4inv_pkg and the matrix4x4_inverse RTL only.
`timescale 1ns / 1ps

module tb;
  import m4inv_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef logic [255:0] uwide_t;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam elem_t ONE = 32'sh0001_0000;
  localparam elem_t EMAX = 32'sh7fff_ffff;
  localparam elem_t EMIN = 32'sh8000_0000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  elem_t     mat_store[16];
  int        row_fill = 0;
  out_item_t inverse_rows_q[$];
  int        errors = 0;
  int        rows_checked = 0;
  int        matrices_sent = 0;
  int        singular_seen = 0;
  int        saturated_seen = 0;
  int        cycles = 0;
  int        stall_mode = 0;

  matrix4x4_inverse dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows still expected", cycles,
               inverse_rows_q.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  // Receiver stalls: long quiet stretches, short bursts, and now and then a long hold.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 999);
    if (r < 5) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 99) < 3) ? 1'b1 : (out_stall && r < 950);
    endcase
  end

  function automatic wide_t ext(elem_t e);
    wide_t w;
    w = e;
    return w;
  endfunction

  function automatic wide_t minor3(int skip_r, int skip_c);
    int rr[3];
    int cc[3];
    int n;
    int m;
    wide_t a[3][3];
    n = 0;
    m = 0;
    for (int k = 0; k < 4; k++) begin
      if (k != skip_r) begin
        rr[n] = k;
        n++;
      end
      if (k != skip_c) begin
        cc[m] = k;
        m++;
      end
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) a[r][c] = ext(mat_store[rr[r] * 4 + cc[c]]);
    return a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
         - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
         + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
  endfunction

  // Exact inverse: adjugate entry scaled by 2^(2*FRAC), divided by the determinant,
  // truncated toward zero, then clipped to the element range.
  task automatic predict_inverse();
    wide_t adj[16];
    wide_t det;
    uwide_t dmag;
    uwide_t num;
    uwide_t q;
    uwide_t lim;
    logic neg;
    logic sing;
    elem_t v[4];
    out_item_t o;
    lim = uwide_t'(1) << 31;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        adj[i * 4 + j] = ((i + j) % 2) ? -minor3(j, i) : minor3(j, i);
    det = 0;
    for (int j = 0; j < 4; j++) det = det + ext(mat_store[j]) * adj[j * 4];
    sing = (det == 0);
    dmag = det < 0 ? uwide_t'(-det) : uwide_t'(det);
    for (int i = 0; i < 4; i++) begin
      o = '0;
      for (int j = 0; j < 4; j++) begin
        v[j] = '0;
        if (!sing) begin
          neg = (adj[i * 4 + j] < 0) ^ (det < 0);
          num = adj[i * 4 + j] < 0 ? uwide_t'(-adj[i * 4 + j]) : uwide_t'(adj[i * 4 + j]);
          q = (num << (2 * FRAC)) / dmag;
          if (neg) begin
            if (q > lim) begin
              q = lim;
              o.saturated = 1'b1;
            end
            v[j] = elem_t'(-q);
          end else begin
            if (q > lim - 1) begin
              q = lim - 1;
              o.saturated = 1'b1;
            end
            v[j] = elem_t'(q);
          end
        end
      end
      o.inv_col0 = v[0];
      o.inv_col1 = v[1];
      o.inv_col2 = v[2];
      o.inv_col3 = v[3];
      o.out_row = i[1:0];
      o.last_row = (i == 3);
      o.singular = sing;
      inverse_rows_q.push_back(o);
    end
    if (sing) singular_seen++;
    if (o.saturated) saturated_seen++;
  endtask

  task automatic send_row(in_item_t row, int gap);
    in_valid <= 1'b1;
    in_item <= row;
    do @(posedge clk); while (in_stall);
    mat_store[row_fill * 4 + 0] = row.elem_col0;
    mat_store[row_fill * 4 + 1] = row.elem_col1;
    mat_store[row_fill * 4 + 2] = row.elem_col2;
    mat_store[row_fill * 4 + 3] = row.elem_col3;
    if (row_fill == 3) begin
      row_fill = 0;
      matrices_sent++;
      predict_inverse();
    end else begin
      row_fill++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_matrix(elem_t m[16]);
    for (int r = 0; r < 4; r++)
      send_row('{m[r * 4], m[r * 4 + 1], m[r * 4 + 2], m[r * 4 + 3]}, pick_gap());
  endtask

  task automatic wait_drained();
    while (inverse_rows_q.size() != 0) @(posedge clk);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
  endtask

  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (inverse_rows_q.size() == 0) begin
        errors++;
        $display("unexpected inverse row at cycle %0d", cycles);
      end else begin
        w = inverse_rows_q.pop_front();
        rows_checked++;
        if (out_item.inv_col0 !== w.inv_col0) report("inv_col0", out_item.inv_col0, w.inv_col0);
        if (out_item.inv_col1 !== w.inv_col1) report("inv_col1", out_item.inv_col1, w.inv_col1);
        if (out_item.inv_col2 !== w.inv_col2) report("inv_col2", out_item.inv_col2, w.inv_col2);
        if (out_item.inv_col3 !== w.inv_col3) report("inv_col3", out_item.inv_col3, w.inv_col3);
        if (out_item.out_row !== w.out_row) report("out_row", out_item.out_row, w.out_row);
        if (out_item.last_row !== w.last_row) report("last_row", out_item.last_row, w.last_row);
        if (out_item.singular !== w.singular) report("singular", out_item.singular, w.singular);
        if (out_item.saturated !== w.saturated)
          report("saturated", out_item.saturated, w.saturated);
      end
    end
  end

  function automatic elem_t rand_small();
    return elem_t'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
  endfunction

  task automatic test_identity_and_scaled();
    elem_t m[16];
    for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? ONE : '0;
    send_matrix(m);
    // Scaled diagonal with two negative entries; the determinant stays positive.
    m[0] = -2 * ONE;
    m[5] = ONE / 2;
    m[10] = -ONE;
    m[15] = 3 * ONE;
    send_matrix(m);
  endtask

  task automatic test_singular();
    elem_t m[16];
    for (int k = 0; k < 16; k++) m[k] = '0;
    send_matrix(m);
    for (int k = 0; k < 16; k++) m[k] = (k < 12) ? rand_small() : m[k - 4];
    send_matrix(m);
    for (int k = 0; k < 16; k++) m[k] = EMAX;
    send_matrix(m);
  endtask

  task automatic test_extremes_and_clipping();
    elem_t m[16];
    for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? EMIN : ((k % 3 == 0) ? EMAX : '0);
    send_matrix(m);
    // Tiny diagonal: the inverse overflows in both directions.
    for (int k = 0; k < 16; k++) m[k] = '0;
    m[0] = 32'sd1;
    m[5] = -32'sd1;
    m[10] = 32'sd3;
    m[15] = 32'sd1;
    send_matrix(m);
    for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? EMAX : 32'sd1;
    send_matrix(m);
  endtask

  task automatic test_random(int n_rows);
    elem_t m[16];
    int kind;
    for (int s = 0; s < n_rows / 4; s++) begin
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 16; k++) begin
        case (kind)
          0, 1, 2: m[k] = elem_t'($urandom);
          3:       m[k] = elem_t'($signed($urandom_range(0, 15)) - 8);
          default: m[k] = rand_small() + ((k % 5 == 0) ? 8 * ONE : '0);
        endcase
      end
      // Occasionally copy a row so the determinant is zero.
      if (kind == 4) for (int c = 0; c < 4; c++) m[12 + c] = m[4 + c];
      send_matrix(m);
      if (s == 20) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_and_scaled();
    test_singular();
    test_extremes_and_clipping();
    test_random(180);
    in_valid <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);
    $display("covered %0d matrices, %0d inverse rows checked", matrices_sent, rows_checked);
    $display("%0d singular and %0d with clipped final rows", singular_seen, saturated_seen);
    if (errors == 0 && inverse_rows_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
